// ===== hw/rtl/spimf_pkg.sv =====
`default_nettype none
package spimf_pkg;

  localparam int HALF_PERIOD_BITS = 16;
  localparam int BYTE_BITS        = 8;
  localparam int BIT_IDX_BITS     = 3;
  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = HALF_PERIOD_BITS;
  localparam int IN_TDATA_BITS    = 16;
  localparam int IN_TUSER_BITS    = 2;
  localparam int OUT_TDATA_BITS   = 16;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_XFER    = 2'd1,
    CMD_SEL_ON  = 2'd2,
    CMD_SEL_OFF = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SPI_MODE     = 3'd0,
    REG_BIT_ORDER    = 3'd1,
    REG_HALF_PERIOD  = 3'd2,
    REG_CS_POLARITY  = 3'd3,
    REG_MISO_PRESENT = 3'd4,
    REG_CS_PRESENT   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_IDLE   = 2'd0,
    ACT_XFER   = 2'd1,
    ACT_SETTLE = 2'd2
  } act_t;

  typedef struct packed {
    logic [1:0]                  spi_mode;
    logic                        lsb_out;
    logic [HALF_PERIOD_BITS-1:0] half_period;
    logic                        cs_pol;
    logic                        miso_present;
    logic                        cs_present;
  } cfg_t;

  typedef struct packed {
    logic                 rx_valid;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 accepted;
    logic                 busy_res;
    logic                 cs_level;
    logic                 mosi;
    logic                 sck;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spi_master_four_modes_core.sv =====
`default_nettype none
// Channel   Dir  Ports                    Carries
// --------  ---  -----------------------  ----------------------------------------
// in_       in   tvalid/tready/tdata/tuser  one pin tick: command, tx byte, MISO level
// out_      out  tvalid/tready/tdata       pin levels, busy, accepted, rx byte/valid
// cfg_      in   we/index/wdata            mode, bit order, half period, CS options
//
// One tick per cycle while out_tready stays high: a transfer goes input register
// -> SPI step logic -> result register, and out_tvalid rises once the result
// register has loaded the tick.
// The per-tick step is a single pass through the engine's next-state logic.
// Reset (rst_n low, synchronous) idles the engine, parks SCK low, MOSI low,
// CS deasserted high, and loads the config defaults.
// out_tready low stalls the result register; the input register then holds,
// and in_tready drops once both stages are full.
module spi_master_four_modes_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [7:0] tx_byte, [8] miso_level, [15:9] zero
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [spimf_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  // in_tuser: [1:0] cmd
  input  logic [spimf_pkg::IN_TUSER_BITS-1:0]  in_tuser,
  // out_tdata: [0] sck, [1] mosi, [2] cs_level, [3] busy_res, [4] accepted,
  //            [12:5] rx_byte, [13] rx_valid, [15:14] zero
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [spimf_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  input  logic                                 cfg_we,
  input  logic [spimf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [spimf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import spimf_pkg::*;

  cfg_t                 cfg;
  res_t                 step_res;
  res_t                 out_res;

  // input register
  logic                 s1_vld_r;
  logic [1:0]           s1_cmd_r;
  logic [BYTE_BITS-1:0] s1_tx_r;
  logic                 s1_miso_r;

  logic                 adv;
  logic                 in_xfer;

  assign adv       = s1_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_vld_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_tuser;
      s1_tx_r   <= in_tdata[BYTE_BITS-1:0];
      s1_miso_r <= in_tdata[BYTE_BITS];
    end
  end

  spimf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // engine state advances exactly once per tick, when the tick moves on
  spimf_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .cfg        (cfg),
    .cmd        (s1_cmd_r),
    .tx_byte    (s1_tx_r),
    .miso_level (s1_miso_r),
    .res        (step_res)
  );

  spimf_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res        (step_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = {2'b00, out_res.rx_valid, out_res.rx_byte, out_res.accepted,
                      out_res.busy_res, out_res.cs_level, out_res.mosi, out_res.sck};

  // completion tick always reports the engine as free
  a_rxv_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.rx_valid |-> !out_res.busy_res)
    else $error("rx_valid with busy set");

  // every taken command starts a transfer or a settle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.accepted |-> out_res.busy_res)
    else $error("accepted command without busy");

  // received byte reads zero outside completion ticks
  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_res.rx_valid |-> out_res.rx_byte == '0)
    else $error("rx_byte nonzero without rx_valid");

  // a held tick in the input register is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |=> s1_vld_r)
    else $error("input register lost a tick");

endmodule
`default_nettype wire

// ===== hw/rtl/spimf_cfg.sv =====
`default_nettype none
module spimf_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [spimf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [spimf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output spimf_pkg::cfg_t                      cfg
);
  import spimf_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spi_mode     <= 2'd0;
      cfg_r.lsb_out      <= 1'b0;
      cfg_r.half_period  <= HALF_PERIOD_BITS'(1);
      cfg_r.cs_pol       <= 1'b0;
      cfg_r.miso_present <= 1'b1;
      cfg_r.cs_present   <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SPI_MODE:     cfg_r.spi_mode     <= cfg_wdata[1:0];
        REG_BIT_ORDER:    cfg_r.lsb_out      <= cfg_wdata[0];
        REG_HALF_PERIOD:  cfg_r.half_period  <= cfg_wdata[HALF_PERIOD_BITS-1:0];
        REG_CS_POLARITY:  cfg_r.cs_pol       <= cfg_wdata[0];
        REG_MISO_PRESENT: cfg_r.miso_present <= cfg_wdata[0];
        REG_CS_PRESENT:   cfg_r.cs_present   <= cfg_wdata[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/spimf_engine.sv =====
`default_nettype none
module spimf_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  spimf_pkg::cfg_t                   cfg,
  input  logic [1:0]                        cmd,
  input  logic [spimf_pkg::BYTE_BITS-1:0]   tx_byte,
  input  logic                              miso_level,
  output spimf_pkg::res_t                   res
);
  import spimf_pkg::*;

  act_t                        act_r,  act_nxt;
  logic [HALF_PERIOD_BITS-1:0] tick_r, tick_nxt;
  logic [BIT_IDX_BITS-1:0]     bit_r,  bit_nxt;
  logic                        half2_r, half2_nxt;
  logic [BYTE_BITS-1:0]        osh_r,  osh_nxt;
  logic [BYTE_BITS-1:0]        ish_r,  ish_nxt;
  logic                        clk_r,  clk_nxt;
  logic                        dat_r,  dat_nxt;
  logic                        sel_r,  sel_nxt;

  logic                        cpol, cpha;
  logic [HALF_PERIOD_BITS:0]   h_len, tick_inc;
  logic                        half_done;
  logic [BIT_IDX_BITS-1:0]     pos_cur, pos_next, bit_inc;
  logic                        got, on;
  logic                        acc, rxv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= ACT_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      half2_r <= 1'b0;
      osh_r   <= '0;
      ish_r   <= '0;
      clk_r   <= 1'b0;
      dat_r   <= 1'b0;
      sel_r   <= 1'b1;
    end else if (step) begin
      act_r   <= act_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      half2_r <= half2_nxt;
      osh_r   <= osh_nxt;
      ish_r   <= ish_nxt;
      clk_r   <= clk_nxt;
      dat_r   <= dat_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    cpol      = cfg.spi_mode[1];
    cpha      = cfg.spi_mode[0];
    h_len     = (cfg.half_period == '0) ? (HALF_PERIOD_BITS+1)'(1)
                                        : {1'b0, cfg.half_period};
    tick_inc  = {1'b0, tick_r} + (HALF_PERIOD_BITS+1)'(1);
    half_done = (tick_inc >= h_len);
    bit_inc   = bit_r + BIT_IDX_BITS'(1);
    pos_cur   = cfg.lsb_out ? bit_r : ~bit_r;
    pos_next  = cfg.lsb_out ? bit_inc : ~bit_inc;
    got       = cfg.miso_present ? miso_level : 1'b1;
    on        = (cmd_t'(cmd) == CMD_SEL_ON);

    act_nxt   = act_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    half2_nxt = half2_r;
    osh_nxt   = osh_r;
    ish_nxt   = ish_r;
    clk_nxt   = clk_r;
    dat_nxt   = dat_r;
    sel_nxt   = sel_r;
    acc       = 1'b0;
    rxv       = 1'b0;

    unique case (act_r)
      ACT_SETTLE: begin
        tick_nxt = tick_inc[HALF_PERIOD_BITS-1:0];
        if (half_done) begin
          tick_nxt = '0;
          act_nxt  = ACT_IDLE;
        end
      end
      ACT_XFER: begin
        tick_nxt = tick_inc[HALF_PERIOD_BITS-1:0];
        if (half_done) begin
          tick_nxt = '0;
          if (!half2_r) begin
            // end of first half: clock edge, sample MISO
            half2_nxt        = 1'b1;
            clk_nxt          = cpha ? cpol : ~cpol;
            ish_nxt[pos_cur] = got;
          end else begin
            half2_nxt = 1'b0;
            clk_nxt   = cpol;
            if (bit_r == BIT_IDX_BITS'(BYTE_BITS-1)) begin
              rxv     = 1'b1;
              bit_nxt = '0;
              act_nxt = ACT_IDLE;
            end else begin
              bit_nxt = bit_inc;
              dat_nxt = osh_r[pos_next];
              clk_nxt = cpha ? ~cpol : cpol;
            end
          end
        end
      end
      default: begin
        act_nxt = ACT_IDLE;
        clk_nxt = cpol;
        case (cmd_t'(cmd)) inside
          CMD_XFER: begin
            acc       = 1'b1;
            osh_nxt   = tx_byte;
            ish_nxt   = '0;
            bit_nxt   = '0;
            half2_nxt = 1'b0;
            tick_nxt  = '0;
            act_nxt   = ACT_XFER;
            dat_nxt   = cfg.lsb_out ? tx_byte[0] : tx_byte[BYTE_BITS-1];
            clk_nxt   = cpha ? ~cpol : cpol;
          end
          CMD_SEL_ON, CMD_SEL_OFF: begin
            if (cfg.cs_present) begin
              acc      = 1'b1;
              sel_nxt  = cfg.cs_pol ? on : ~on;
              tick_nxt = '0;
              act_nxt  = ACT_SETTLE;
            end
          end
          default: ;
        endcase
      end
    endcase

    res.sck      = clk_nxt;
    res.mosi     = dat_nxt;
    res.cs_level = sel_nxt;
    res.busy_res = (act_nxt == ACT_XFER) || (act_nxt == ACT_SETTLE);
    res.accepted = acc;
    res.rx_valid = rxv;
    res.rx_byte  = rxv ? ish_nxt : '0;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spimf_out_stage.sv =====
`default_nettype none
module spimf_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  spimf_pkg::res_t res,
  input  logic            out_tready,
  output logic            out_tvalid,
  output spimf_pkg::res_t out_res
);
  import spimf_pkg::*;

  logic vld_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spimf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_TICKS = 224;   // random ticks per register setting
  localparam int NUM_PHASES  = 8;

  // Pacing of the two stream sides, one per phase
  typedef enum int {
    PACE_FULL,
    PACE_SLOW_SRC,
    PACE_SLOW_SINK,
    PACE_BOTH
  } pace_t;

  // One pin tick as the source side sees it
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx;
    logic       miso;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;   // [7:0] tx_byte, [8] miso_level, rest zero
  logic [IN_TUSER_BITS-1:0]  in_tuser = '0;   // [1:0] cmd
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;       // [0] sck .. [13] rx_valid, see res_t
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  spi_master_four_modes_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Register mirror, kept in step with every cfg_ write (reset defaults)
  // ---------------------------------------------------------------------------
  logic [1:0]  cfg_mode    = 2'd0;   // [1] CPOL, [0] CPHA
  logic        cfg_lsb     = 1'b0;
  logic [15:0] cfg_half    = 16'd1;
  logic        cfg_cs_hi   = 1'b0;
  logic        cfg_miso_on = 1'b1;
  logic        cfg_cs_on   = 1'b1;

  // ---------------------------------------------------------------------------
  // Engine state of the SPI pin sequencer, as predicted
  // ---------------------------------------------------------------------------
  act_t        eng_act    = ACT_IDLE;
  logic [16:0] half_ticks = '0;      // one spare bit: h may shrink mid-half
  logic [2:0]  bit_idx    = '0;
  logic        sec_half   = 1'b0;
  logic [7:0]  tx_sr      = '0;
  logic [7:0]  rx_sr      = '0;
  logic        sck_lvl    = 1'b0;
  logic        mosi_lvl   = 1'b0;
  logic        cs_lvl     = 1'b1;    // deasserted, active low after reset

  tick_t pending[$];       // ticks waiting for the driver
  res_t  pin_expect[$];    // predicted pin states, oldest first

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int n_queued = 0;
  int n_ticks = 0;
  int n_taken = 0;
  int n_refused = 0;
  int n_rx = 0;
  int n_err = 0;
  int cycles = 0;

  // Bit position in the shift registers for the current bit, per bit order
  function automatic logic [2:0] shift_pos();
    return cfg_lsb ? bit_idx : 3'd7 - bit_idx;
  endfunction

  // Drive MOSI for the current bit; SCK leads with an edge only in CPHA=1
  function automatic void launch_bit();
    mosi_lvl = tx_sr[shift_pos()];
    sck_lvl  = cfg_mode[0] ? ~cfg_mode[1] : cfg_mode[1];
  endfunction

  // Advance the sequencer by one tick and return the pin state after it.
  // Registers are read live, so a mid-transfer write takes effect at once.
  function automatic res_t spi_tick(cmd_t cmd, logic [7:0] tx, logic miso);
    res_t        r;
    logic [16:0] hl;
    logic        on;
    hl = (cfg_half == '0) ? 17'd1 : {1'b0, cfg_half};
    r  = '0;
    if (eng_act != ACT_XFER && eng_act != ACT_SETTLE) begin
      eng_act = ACT_IDLE;
      sck_lvl = cfg_mode[1];           // parked at current CPOL
      if (cmd == CMD_XFER) begin
        r.accepted = 1'b1;
        tx_sr      = tx;
        rx_sr      = '0;
        bit_idx    = '0;
        sec_half   = 1'b0;
        half_ticks = '0;
        eng_act    = ACT_XFER;
        launch_bit();
      end else if ((cmd == CMD_SEL_ON || cmd == CMD_SEL_OFF) && cfg_cs_on) begin
        on         = (cmd == CMD_SEL_ON);
        r.accepted = 1'b1;
        cs_lvl     = ~(on ^ cfg_cs_hi);
        half_ticks = '0;
        eng_act    = ACT_SETTLE;
      end
    end else if (eng_act == ACT_SETTLE) begin
      half_ticks++;
      if (half_ticks >= hl) begin
        half_ticks = '0;
        eng_act    = ACT_IDLE;
      end
    end else begin
      half_ticks++;
      if (half_ticks >= hl) begin
        half_ticks = '0;
        if (!sec_half) begin
          // end of first half: clock edge and MISO sample
          sec_half = 1'b1;
          sck_lvl  = cfg_mode[0] ? cfg_mode[1] : ~cfg_mode[1];
          rx_sr[shift_pos()] = cfg_miso_on ? miso : 1'b1;
        end else begin
          sec_half = 1'b0;
          sck_lvl  = cfg_mode[1];
          if (bit_idx == 3'd7) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_sr;
            bit_idx    = '0;
            eng_act    = ACT_IDLE;
          end else begin
            bit_idx++;
            launch_bit();
          end
        end
      end
    end
    r.sck      = sck_lvl;
    r.mosi     = mosi_lvl;
    r.cs_level = cs_lvl;
    r.busy_res = (eng_act == ACT_XFER || eng_act == ACT_SETTLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Source driver: presents queued ticks, predicts on each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : src_drv
    tick_t nxt;
    res_t  pred;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred = spi_tick(cmd_t'(in_tuser), in_tdata[7:0], in_tdata[8]);
        pin_expect.push_back(pred);
        n_ticks++;
        if (pred.accepted)
          n_taken++;
        else if (cmd_t'(in_tuser) != CMD_NONE)
          n_refused++;
      end
      // slot is free once the held tick has gone (or nothing was held)
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.cmd;
          in_tdata  <= {7'b0, nxt.miso, nxt.tx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares every result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t  %s mismatch: expected %0h, got %0h", $time, name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : res_mon
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[13:0]);
        if (pin_expect.size() == 0) begin
          $display("%0t  unexpected result: expected none, got %h", $time, out_tdata);
          n_err++;
        end else begin
          want = pin_expect.pop_front();
          check_field("sck",      want.sck,      got.sck);
          check_field("mosi",     want.mosi,     got.mosi);
          check_field("cs_level", want.cs_level, got.cs_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("accepted", want.accepted, got.accepted);
          check_field("rx_byte",  want.rx_byte,  got.rx_byte);
          check_field("rx_valid", want.rx_valid, got.rx_valid);
          if (got.rx_valid) n_rx++;
        end
      end
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t  timeout after %0d cycles, %0d results outstanding",
               $time, cycles, pin_expect.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_tick(cmd_t c, logic [7:0] tx, logic m);
    pending.push_back(tick_t'{cmd: c, tx: tx, miso: m});
    n_queued++;
  endtask

  // Filler ticks; a command in here that lands while busy must be refused
  task automatic pad_ticks(int k);
    for (int i = 0; i < k; i++)
      queue_tick(($urandom_range(99) < 20) ? cmd_t'($urandom_range(3)) : CMD_NONE,
                 8'($urandom), 1'($urandom));
  endtask

  // Register writes only with nothing in flight; checked on the falling
  // edge so the driver's and the monitor's updates have all settled
  task automatic wait_drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_tvalid || pin_expect.size() != 0);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_SPI_MODE:     cfg_mode    = val[1:0];
      REG_BIT_ORDER:    cfg_lsb     = val[0];
      REG_HALF_PERIOD:  cfg_half    = val;
      REG_CS_POLARITY:  cfg_cs_hi   = val[0];
      REG_MISO_PRESENT: cfg_miso_on = val[0];
      REG_CS_PRESENT:   cfg_cs_on   = val[0];
      default: ;
    endcase
  endtask

  // Mostly well-formed command sequences: each command followed by the ticks it
  // keeps the engine busy, at times one to three more, so the next one is taken.
  // The rest is stray commands, which can knock the pacing off.
  task automatic gen_traffic(int n);
    int base;
    int h;
    int pick;
    base = n_queued;
    h = (cfg_half == '0) ? 1 : int'(cfg_half);
    while (n_queued - base < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_tick(CMD_XFER, 8'($urandom), 1'($urandom));
        pad_ticks(16 * h);
        if ($urandom_range(3) == 0) pad_ticks($urandom_range(1, 3));
      end else if (pick < 75) begin
        queue_tick($urandom_range(1) ? CMD_SEL_ON : CMD_SEL_OFF,
                   8'($urandom), 1'($urandom));
        pad_ticks(h);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) queue_tick(CMD_NONE, 8'($urandom), 1'($urandom));
      end else begin
        queue_tick(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  function automatic void set_pace(pace_t p);
    case (p)
      PACE_FULL:      begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      PACE_SLOW_SRC:  begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
      PACE_SLOW_SINK: begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
      default:        begin snd_idle_pct = 9;  rcv_stall_pct = 9;  end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [15:0] half_sel[NUM_PHASES] = '{16'd1, 16'd2, 16'd0, 16'd3,
                                          16'd1, 16'd4, 16'd2, 16'd1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(PACE_FULL);

    // Directed, reset settings (mode 0, MSB first, h=1, active-low CS):
    // select, one byte of all ones with every command thrown at it while
    // busy, then release.
    queue_tick(CMD_SEL_ON, 8'h00, 1'b0);
    queue_tick(CMD_NONE,   8'hFF, 1'b1);
    queue_tick(CMD_XFER,   8'hFF, 1'b0);
    for (int i = 0; i < 16; i++)
      queue_tick(cmd_t'(i % 4), 8'h00, 1'(i >> 1));
    queue_tick(CMD_SEL_OFF, 8'h00, 1'b1);
    queue_tick(CMD_NONE,    8'h00, 1'b0);
    wait_drain();

    // No CS line: select commands refused. Half period of zero acts as one.
    set_reg(REG_CS_PRESENT, 16'd0);
    set_reg(REG_HALF_PERIOD, 16'd0);
    queue_tick(CMD_SEL_ON,  8'h00, 1'b0);
    queue_tick(CMD_SEL_OFF, 8'hFF, 1'b1);
    queue_tick(CMD_NONE,    8'h00, 1'b0);
    wait_drain();

    // Random phases; every register rewritten each time
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_reg(REG_SPI_MODE,     16'(p % 4));
      set_reg(REG_BIT_ORDER,    16'((p >> 1) & 1));
      set_reg(REG_HALF_PERIOD,  half_sel[p]);
      set_reg(REG_CS_POLARITY,  16'(p % 3 == 1));
      set_reg(REG_MISO_PRESENT, 16'(p != 3 && p != 6));
      set_reg(REG_CS_PRESENT,   16'(p != 5));
      set_pace(pace_t'(p % 4));
      gen_traffic(PHASE_TICKS / 2);
      if (p == 1) wait_drain();   // source holds off until all results are back
      gen_traffic(PHASE_TICKS / 2);
      wait_drain();

      // Longest half period: start a byte, then let the next phase's writes
      // land mid-transfer (shorter h ends the half at once, mode and CS
      // polarity change under a live transfer).
      if (p == 4) begin
        set_reg(REG_HALF_PERIOD, 16'hFFFF);
        queue_tick(CMD_XFER, 8'hA5, 1'b1);
        pad_ticks(6);
        wait_drain();
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d ticks: %0d commands taken, %0d refused, %0d bytes received,",
             n_ticks, n_taken, n_refused, n_rx);
    $display("over all four SPI modes, both bit orders, CS/MISO absent, h from 0 to 65535.");
    if (n_err == 0 && pin_expect.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_err, pin_expect.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
